### design/rott_pkg.sv
// Shared types, codes and defaults for the recency ordered timeout table.
`default_nettype none
package rott_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int SWEEP_LIMIT  = 16;
  localparam int RM_W         = $clog2(SWEEP_LIMIT + 1);

  // request codes
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_FIND   = 3'd1;
  localparam logic [2:0] FN_BUMP   = 3'd2;
  localparam logic [2:0] FN_DELETE = 3'd3;
  localparam logic [2:0] FN_SWEEP  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_REPORT  = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd60;
  localparam logic        REPORT_RST  = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_BUMP,
    OP_DEL,
    OP_POP
  } op_e;

  typedef enum logic [2:0] {
    RK_PLAIN,
    RK_FULL,
    RK_NOTFOUND,
    RK_HIT,
    RK_XKEY,
    RK_COUNT
  } rkind_e;

  typedef struct packed {
    logic   load;
    logic   find;
    op_e    op;
    logic   sweep_rd;
    logic   emit;
    rkind_e kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       hit;
    logic       full;
    logic       cnt_zero;
    logic       at_limit;
    logic       expire;
    logic       report;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] stamp;
    logic        xvalid;
    logic [31:0] xkey;
    logic [4:0]  xcount;
    logic [4:0]  occ;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

### design/rott_ctrl.sv
// Request sequencer: accepts a word, steps through lookup, update and sweep.
`default_nettype none
module rott_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  rott_pkg::sts_t sts_i,
  output rott_pkg::cmd_t cmd_o
);
  import rott_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIND  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.kind   = RK_PLAIN;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FIND;
        end
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.func == FN_SWEEP) begin
          state_d = S_SWEEP;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          case (sts_i.func)
            FN_INSERT: begin
              if (sts_i.full) begin
                cmd_o.kind = RK_FULL;
              end else begin
                cmd_o.op = OP_PUSH;
              end
            end
            FN_FIND, FN_BUMP, FN_DELETE: begin
              if (!sts_i.hit) begin
                cmd_o.kind = RK_NOTFOUND;
              end else begin
                cmd_o.kind = RK_HIT;
                if (sts_i.func == FN_BUMP) cmd_o.op = OP_BUMP;
                else if (sts_i.func == FN_DELETE) cmd_o.op = OP_DEL;
              end
            end
            default: cmd_o.kind = RK_PLAIN;
          endcase
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        if (!sts_i.cnt_zero && !sts_i.at_limit && sts_i.expire) begin
          // oldest entry has aged out
          if (!sts_i.report) begin
            cmd_o.op = OP_POP;
          end else if (sts_i.out_free) begin
            cmd_o.op   = OP_POP;
            cmd_o.emit = 1'b1;
            cmd_o.kind = RK_XKEY;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = RK_COUNT;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a load only ever starts from idle and is followed by the lookup step
  a_load_then_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_FIND))
    else $error("load not followed by lookup");

  a_pop_only_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_POP) |-> (state_q == S_SWEEP))
    else $error("pop outside sweep");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("ready outside idle");

endmodule
`default_nettype wire

### design/rott_dp.sv
// Datapath: recency-ordered cell row, lookup, expiry compare and result register.
`default_nettype none
module rott_dp #(
  parameter int CAPACITY = rott_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rott_pkg::KEY_BITS_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire  [2:0]     func_i,
  input  wire  [31:0]    key_i,
  input  wire  [31:0]    now_i,
  input  wire            cfg_we_i,
  input  wire            cfg_idx_i,
  input  wire  [31:0]    cfg_data_i,
  input  rott_pkg::cmd_t cmd_i,
  output rott_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output rott_pkg::res_t res_o
);
  import rott_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_BITS-1:0] ckey_q   [CAPACITY];
  logic [31:0]         cstamp_q [CAPACITY];

  logic [2:0]          func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         now_q;
  logic [CAPACITY-1:0] match_q;
  logic [IW-1:0]       pos_q, pos_d;
  logic                hit_q;
  logic [CW-1:0]       count_q, count_d;
  logic [RM_W-1:0]     removed_q, removed_d;
  logic [31:0]         tmo_q;
  logic                rep_q;
  logic                ov_q, ov_d;
  res_t                res_q, res_d;

  logic [KEY_BITS-1:0] key_in;
  logic [IW-1:0]       tail;
  logic [IW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_stamp;
  logic [31:0]         tail_stamp;
  logic [63:0]         rd_key64;
  logic                out_free;

  assign key_in     = KEY_BITS'(64'(key_i));
  assign tail       = IW'(count_q - 1'b1);
  assign rd_addr    = cmd_i.sweep_rd ? tail : pos_q;
  assign rd_key     = ckey_q[rd_addr];
  assign rd_stamp   = cstamp_q[rd_addr];
  assign tail_stamp = cstamp_q[tail];
  assign rd_key64   = 64'(rd_key);
  assign out_free   = !ov_q || out_ready_i;

  // status must not depend on the command, so expiry reads the tail directly
  assign sts_o.func     = func_q;
  assign sts_o.hit      = hit_q;
  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.at_limit = (removed_q == RM_W'(SWEEP_LIMIT));
  assign sts_o.expire   = ((now_q - tail_stamp) >= tmo_q);
  assign sts_o.report   = rep_q;
  assign sts_o.out_free = out_free;

  // first match from the newest end
  always_comb begin
    pos_d = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) pos_d = IW'(i);
    end
  end

  always_comb begin
    count_d   = count_q;
    removed_d = removed_q;
    case (cmd_i.op)
      OP_PUSH:        count_d = count_q + 1'b1;
      OP_DEL, OP_POP: count_d = count_q - 1'b1;
      default:        count_d = count_q;
    endcase
    if (cmd_i.op == OP_POP) removed_d = removed_q + 1'b1;
    if (cmd_i.load) removed_d = '0;
  end

  always_comb begin
    res_d        = '0;
    res_d.status = ST_OK;
    res_d.occ    = 5'(count_d);
    res_d.last   = 1'b1;
    case (cmd_i.kind)
      RK_FULL:     res_d.status = ST_FULL;
      RK_NOTFOUND: res_d.status = ST_NOTFOUND;
      RK_HIT: begin
        res_d.found = 1'b1;
        res_d.stamp = rd_stamp;
      end
      RK_XKEY: begin
        res_d.xvalid = 1'b1;
        res_d.xkey   = rd_key64[31:0];
        res_d.last   = 1'b0;
      end
      RK_COUNT: res_d.xcount = 5'(removed_q);
      default:  res_d.status = ST_OK;
    endcase
    ov_d = ov_q;
    if (cmd_i.emit) ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
  end

  // cell row: cells shift from fixed neighbors; cell 0 takes pushed/bumped entries
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (i == 0) begin
        if (cmd_i.op == OP_PUSH) begin
          ckey_q[i]   <= key_q;
          cstamp_q[i] <= now_q;
        end else if (cmd_i.op == OP_BUMP) begin
          ckey_q[i]   <= rd_key;
          cstamp_q[i] <= now_q;
        end
      end
      if (i > 0) begin
        if (cmd_i.op == OP_PUSH ||
            (cmd_i.op == OP_BUMP && IW'(i) <= pos_q)) begin
          ckey_q[i]   <= ckey_q[(i > 0) ? i - 1 : 0];
          cstamp_q[i] <= cstamp_q[(i > 0) ? i - 1 : 0];
        end
      end
      if (i < CAPACITY - 1) begin
        if (cmd_i.op == OP_DEL && IW'(i) >= pos_q) begin
          ckey_q[i]   <= ckey_q[(i < CAPACITY - 1) ? i + 1 : i];
          cstamp_q[i] <= cstamp_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        match_q[i] <= (CW'(i) < count_q) && (ckey_q[i] == key_in);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_in;
      now_q  <= now_i;
    end
    if (cmd_i.find) begin
      pos_q <= pos_d;
      hit_q <= |match_q;
    end
    if (cmd_i.emit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      removed_q <= '0;
      tmo_q     <= TIMEOUT_RST;
      rep_q     <= REPORT_RST;
      ov_q      <= 1'b0;
    end else begin
      count_q   <= count_d;
      removed_q <= removed_d;
      ov_q      <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIMEOUT: tmo_q <= cfg_data_i;
          REG_REPORT:  rep_q <= cfg_data_i[0];
          default:     rep_q <= rep_q;
        endcase
      end
    end
  end

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result written over a pending word");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP || cmd_i.op == OP_DEL) |-> (count_q != '0))
    else $error("removal from empty table");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    removed_q <= RM_W'(SWEEP_LIMIT))
    else $error("sweep removed too many");

endmodule
`default_nettype wire

### design/recency_ordered_timeout_table_top.sv
// Result word: lookup step, then execute step writes the out reg.
// A new request waits until the last result is issued; a sweep pops expired entries one by one.
// A stalled result output holds the sequencer for as long as the stall lasts.
// Reset (async, active low) empties the table and restores timeout 60, reporting on.
// Table contents need no clearing pass; entries past the occupancy are never read.
`default_nettype none
module recency_ordered_timeout_table_top #(
  parameter int CAPACITY = rott_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rott_pkg::KEY_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // key[31:0], now_seconds[63:32]
  input  wire  [2:0]  s_axis_tuser,   // func[2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [79:0] m_axis_tdata,   // found[0], stamp[32:1], expired_key[64:33],
                                      // expired_count[69:65], occupancy[74:70], zero pad
  output logic [2:0]  m_axis_tuser,   // status[1:0], expired_valid[2]
  output logic        m_axis_tlast,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [31:0] cfg_data_i
);
  import rott_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  rott_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rott_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (s_axis_tuser),
    .key_i       (s_axis_tdata[31:0]),
    .now_i       (s_axis_tdata[63:32]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.occ, res.xcount, res.xkey, res.stamp, res.found};
  assign m_axis_tuser = {res.xvalid, res.status};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

### test/tb_recency_ordered_timeout_table_top.sv
// Self-checking stream testbench for the recency ordered timeout table, with a table predictor.
`timescale 1ns / 100ps
module tb_recency_ordered_timeout_table_top;
  import rott_pkg::*;

  localparam int TBL_DEPTH   = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 8;

  // func codes the block treats as no-ops
  localparam logic [2:0] FN_RSVD_A = 3'd5;
  localparam logic [2:0] FN_RSVD_B = 3'd6;
  localparam logic [2:0] FN_RSVD_C = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] key;
    logic [31:0] now_s;
  } req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // key[31:0], now_seconds[63:32]
  logic [2:0]  s_axis_tuser  = '0;  // func[2:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [79:0] m_axis_tdata;        // found, stamp, expired_key, expired_count, occupancy
  wire  [2:0]  m_axis_tuser;        // status[1:0], expired_valid[2]
  wire         m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [31:0] cfg_data_i    = '0;

  recency_ordered_timeout_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial forever #10 clk_i = ~clk_i;

  // predicted table, newest entry in slot 0
  logic [31:0] tbl_key   [TBL_DEPTH];
  logic [31:0] tbl_stamp [TBL_DEPTH];
  int          tbl_count;
  logic [31:0] mdl_timeout = TIMEOUT_RST;
  logic        mdl_report  = REPORT_RST;

  req_t        req_queue[$];
  res_t        want_results[$];
  int          fail_count    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count   = 0;
  bit          load_next;
  req_t        nxt_req;
  logic [31:0] tb_now;
  logic [31:0] key_pool[6];

  function automatic res_t make_res(logic [1:0] status, logic found, logic [31:0] stamp,
                                    logic xvalid, logic [31:0] xkey, logic [4:0] xcount,
                                    logic last);
    res_t r;
    r.status = status;
    r.found  = found;
    r.stamp  = stamp;
    r.xvalid = xvalid;
    r.xkey   = xkey;
    r.xcount = xcount;
    r.occ    = tbl_count[4:0];
    r.last   = last;
    return r;
  endfunction

  task automatic drop_slot(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_key[i]   = tbl_key[i + 1];
      tbl_stamp[i] = tbl_stamp[i + 1];
    end
    tbl_count--;
  endtask

  task automatic push_newest(logic [31:0] k, logic [31:0] s);
    for (int i = tbl_count; i > 0; i--) begin
      tbl_key[i]   = tbl_key[i - 1];
      tbl_stamp[i] = tbl_stamp[i - 1];
    end
    tbl_key[0]   = k;
    tbl_stamp[0] = s;
    tbl_count++;
  endtask

  // advance the table by one request and queue the words it should produce
  task automatic apply_request(logic [2:0] fn, logic [31:0] k, logic [31:0] t);
    int          pos;
    int          removed;
    bit          stop;
    logic [31:0] age;
    logic [31:0] hit_key;
    logic [31:0] hit_stamp;
    case (fn)
      FN_INSERT: begin
        if (tbl_count >= TBL_DEPTH) begin
          want_results.push_back(make_res(ST_FULL, 1'b0, '0, 1'b0, '0, '0, 1'b1));
        end else begin
          push_newest(k, t);
          want_results.push_back(make_res(ST_OK, 1'b0, '0, 1'b0, '0, '0, 1'b1));
        end
      end
      FN_FIND, FN_BUMP, FN_DELETE: begin
        pos = -1;
        for (int i = 0; i < tbl_count; i++)
          if (pos < 0 && tbl_key[i] == k) pos = i;
        if (pos < 0) begin
          want_results.push_back(make_res(ST_NOTFOUND, 1'b0, '0, 1'b0, '0, '0, 1'b1));
        end else begin
          hit_key   = tbl_key[pos];
          hit_stamp = tbl_stamp[pos];
          if (fn == FN_BUMP) begin
            drop_slot(pos);
            push_newest(hit_key, t);
          end else if (fn == FN_DELETE) begin
            drop_slot(pos);
          end
          want_results.push_back(make_res(ST_OK, 1'b1, hit_stamp, 1'b0, '0, '0, 1'b1));
        end
      end
      FN_SWEEP: begin
        removed = 0;
        stop    = 1'b0;
        while (tbl_count > 0 && removed < SWEEP_LIMIT && !stop) begin
          age = t - tbl_stamp[tbl_count - 1];
          if (age < mdl_timeout) begin
            stop = 1'b1;
          end else begin
            hit_key = tbl_key[tbl_count - 1];
            tbl_count--;
            removed++;
            if (mdl_report)
              want_results.push_back(make_res(ST_OK, 1'b0, '0, 1'b1, hit_key, '0, 1'b0));
          end
        end
        want_results.push_back(make_res(ST_OK, 1'b0, '0, 1'b0, '0, removed[4:0], 1'b1));
      end
      default: begin
        want_results.push_back(make_res(ST_OK, 1'b0, '0, 1'b0, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.found  = m_axis_tdata[0];
    got.stamp  = m_axis_tdata[32:1];
    got.xkey   = m_axis_tdata[64:33];
    got.xcount = m_axis_tdata[69:65];
    got.occ    = m_axis_tdata[74:70];
    got.status = m_axis_tuser[1:0];
    got.xvalid = m_axis_tuser[2];
    got.last   = m_axis_tlast;
    if (want_results.size() == 0) begin
      $error("result word with nothing expected");
      fail_count++;
    end else begin
      want = want_results.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("found", 32'(want.found), 32'(got.found));
      check_field("stamp", want.stamp, got.stamp);
      check_field("expired_valid", 32'(want.xvalid), 32'(got.xvalid));
      check_field("expired_key", want.xkey, got.xkey);
      check_field("expired_count", 32'(want.xcount), 32'(got.xcount));
      check_field("occupancy", 32'(want.occ), 32'(got.occ));
      check_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  // request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      load_next = !s_axis_tvalid || s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        apply_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (load_next) begin
        if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt_req = req_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt_req.now_s, nxt_req.key};
          s_axis_tuser  <= nxt_req.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic add_req(logic [2:0] fn, logic [31:0] k, logic [31:0] t);
    req_t r;
    r.func  = fn;
    r.key   = k;
    r.now_s = t;
    req_queue.push_back(r);
  endtask

  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return key_pool[$urandom_range(0, 5)];
    if (roll < 75) return 32'h0;
    if (roll < 80) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [31:0] next_time();
    if ($urandom_range(0, 24) == 0) tb_now = $urandom();
    else tb_now = tb_now + $urandom_range(0, 8);
    return tb_now;
  endfunction

  task automatic gen_phase(int n_items);
    int          made;
    int          roll;
    logic [2:0]  rsvd[3];
    rsvd = '{FN_RSVD_A, FN_RSVD_B, FN_RSVD_C};
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        // burst of inserts, often enough to fill the table
        repeat ($urandom_range(4, 18)) begin
          add_req(FN_INSERT, pick_key(), next_time());
          made++;
        end
      end else if (roll < 22) begin
        tb_now = tb_now + $urandom_range(0, 200);
        add_req(FN_SWEEP, $urandom(), tb_now);
        made++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      add_req(FN_INSERT, pick_key(), next_time());
        else if (roll < 50) add_req(FN_FIND, pick_key(), next_time());
        else if (roll < 65) add_req(FN_BUMP, pick_key(), next_time());
        else if (roll < 80) add_req(FN_DELETE, pick_key(), next_time());
        else if (roll < 92) add_req(FN_SWEEP, $urandom(), next_time());
        else                add_req(rsvd[$urandom_range(0, 2)], pick_key(), next_time());
        made++;
      end
    end
  endtask

  // block until every word went in and every result came back, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (req_queue.size() != 0 || s_axis_tvalid || want_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_TIMEOUT) mdl_timeout = data;
    else mdl_report = data[0];
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tbl_count     = 0;
    tb_now        = '0;
    send_idle_pct = 33;
    recv_idle_pct = 88;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset configuration: timeout 60, reporting on
    add_req(FN_INSERT, 32'h0, 32'h0);
    add_req(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FN_INSERT, 32'h0, 32'd5);             // duplicate key
    add_req(FN_FIND, 32'h0, 32'd6);               // newest duplicate wins
    add_req(FN_FIND, 32'hFFFF_FFFF, 32'd7);
    add_req(FN_FIND, 32'h0001_2345, 32'd8);       // miss
    add_req(FN_BUMP, 32'h0, 32'd20);
    add_req(FN_DELETE, 32'hFFFF_FFFF, 32'd21);
    add_req(FN_DELETE, 32'h0001_2345, 32'd22);
    add_req(FN_BUMP, 32'h0001_2345, 32'd23);
    add_req(FN_RSVD_A, 32'hFFFF_FFFF, 32'd24);
    add_req(FN_RSVD_B, 32'h0, 32'd25);
    add_req(FN_RSVD_C, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    add_req(FN_SWEEP, 32'h0, 32'd30);             // nothing old enough
    add_req(FN_SWEEP, 32'hFFFF_FFFF, 32'd70);     // age exactly 70, one expires
    add_req(FN_INSERT, 32'hA5A5_A5A5, 32'hFFFF_FFF0);
    add_req(FN_SWEEP, 32'h0, 32'h0000_0010);      // time wrapped: old one goes, new one stays

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: begin write_reg(REG_TIMEOUT, 32'd60); write_reg(REG_REPORT, 32'd1); end
        1: begin write_reg(REG_TIMEOUT, 32'd0); write_reg(REG_REPORT, 32'd1); end
        2: begin write_reg(REG_TIMEOUT, 32'hFFFF_FFFF); write_reg(REG_REPORT, 32'd0); end
        3: begin write_reg(REG_TIMEOUT, $urandom_range(5, 40)); write_reg(REG_REPORT, 32'd0); end
        4: begin write_reg(REG_TIMEOUT, $urandom_range(5, 40)); write_reg(REG_REPORT, 32'd1); end
        default: begin write_reg(REG_TIMEOUT, 32'd1); write_reg(REG_REPORT, 32'd1); end
      endcase
      if (ph < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 88;
      end else if (ph < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      foreach (key_pool[i]) key_pool[i] = $urandom();
      gen_phase(33);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
design/rott_pkg.sv
design/rott_ctrl.sv
design/rott_dp.sv
design/recency_ordered_timeout_table_top.sv
test/tb_recency_ordered_timeout_table_top.sv
